// ----- rtl/smpq_pkg.sv -----
package smpq_pkg;

    // sizing
    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // command codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // one stored entry
    typedef struct packed {
        logic signed [KEY_BITS-1:0]   key;
        logic signed [VALUE_BITS-1:0] value;
    } entry_t;

    // request beat
    typedef struct packed {
        logic [1:0]                   command;
        logic signed [KEY_BITS-1:0]   prio_key;
        logic signed [VALUE_BITS-1:0] payload;
    } req_t;

    // response beat
    typedef struct packed {
        logic                         top_valid;
        logic signed [KEY_BITS-1:0]   top_key;
        logic signed [VALUE_BITS-1:0] top_value;
        logic [COUNT_BITS-1:0]        entry_count;
        logic [1:0]                   status;
    } rsp_t;

    // broadcast control to every cell of the row
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t item;
    } cell_ctrl_t;

endpackage

// ----- rtl/smpq_cell.sv -----
module smpq_cell
    import smpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       up_ge,
    input  logic       up_valid,
    input  entry_t     up_entry,
    input  logic       down_valid,
    input  entry_t     down_entry,
    output logic       ge,
    output logic       valid,
    output entry_t     entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    // held entry ranks at or ahead of the incoming one
    assign ge = valid_reg && ($signed(entry_reg.key) >= $signed(ctrl.item.key));

    // push shifts down behind the insertion point, pop shifts up
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.push)
        begin
            if (!ge)
            begin
                if (up_ge)
                    entry_next = ctrl.item;
                else
                    entry_next = up_entry;
            end
            valid_next = valid_reg | up_valid;
        end
        else if (ctrl.pop)
        begin
            entry_next = down_entry;
            valid_next = down_valid;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

`ifndef SYNTHESIS
    // row stays sorted against the cell below
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && down_valid) |-> ($signed(entry_reg.key) >= $signed(down_entry.key)))
        else $error("cell order broken");
`endif

endmodule

// ----- rtl/stable_max_priority_queue.sv -----
// Stable max priority queue built as a sorted row of cells.
// Request channel (req_valid / req_ready / req): command push, pop or query,
// with a signed key and a value for push. Response channel (rsp_valid /
// rsp_ready / rsp): one beat per request with the top entry after the
// request, its valid flag, the entry count and a status.
// Cell 0 holds the top; entries run in serving order, and a pushed entry
// lands behind every held entry whose key is greater or equal, so equal keys
// leave oldest first. Every cell compares its key with the broadcast key in
// parallel, and all cells shift together.
// The response is registered and appears in the cycle after the request beat.
// Throughput: one request per cycle while rsp_ready is high; the figure is
// set by the single response register between the two channels.
// Push to a full queue is dropped with status full; pop on an empty queue
// is ignored with status empty.
// Reset clears every cell's occupancy flag and the count; the queue is
// empty at once, with no clearing pass.
// When the receiver stalls, the response holds and req_ready stays low
// until the pending beat is taken.
module stable_max_priority_queue
    import smpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic                  req_fire;
    logic                  full;
    logic                  empty;
    logic                  do_push;
    logic                  do_pop;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    entry_t                item;
    entry_t                top;
    logic                  top_valid;
    cell_ctrl_t            ctrl;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic   [CAPACITY-1:0] cell_ge;
    logic   [CAPACITY-1:0] cell_valid;
    entry_t                cell_entry [CAPACITY];

    // handshake
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    assign full  = (count_reg == COUNT_BITS'(CAPACITY));
    assign empty = (count_reg == '0);

    assign item.key   = req.prio_key;
    assign item.value = req.payload;

    // command decode
    always_comb
    begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        status  = STATUS_OK;
        unique case (req.command)
            CMD_PUSH:
            begin
                if (full)
                    status = STATUS_FULL;
                else
                    do_push = 1'b1;
            end
            CMD_POP:
            begin
                if (empty)
                    status = STATUS_EMPTY;
                else
                    do_pop = 1'b1;
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase
    end

    assign ctrl.push = req_fire && do_push;
    assign ctrl.pop  = req_fire && do_pop;
    assign ctrl.item = item;

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
            count_next = count_reg + COUNT_BITS'(1);
        else if (ctrl.pop)
            count_next = count_reg - COUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // row of cells, cell 0 at the top
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   up_ge;
        logic   up_valid;
        entry_t up_entry;
        logic   down_valid;
        entry_t down_entry;

        if (i == 0)
        begin : g_head
            assign up_ge    = 1'b1;
            assign up_valid = 1'b1;
            assign up_entry = item;
        end
        else
        begin : g_body
            assign up_ge    = cell_ge[i-1];
            assign up_valid = cell_valid[i-1];
            assign up_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign down_valid = 1'b0;
            assign down_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign down_valid = cell_valid[i+1];
            assign down_entry = cell_entry[i+1];
        end

        smpq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .up_ge      (up_ge),
            .up_valid   (up_valid),
            .up_entry   (up_entry),
            .down_valid (down_valid),
            .down_entry (down_entry),
            .ge         (cell_ge[i]),
            .valid      (cell_valid[i]),
            .entry      (cell_entry[i])
        );
    end

    // top entry after this request
    always_comb
    begin
        if (do_push)
            top = cell_ge[0] ? cell_entry[0] : item;
        else if (do_pop)
            top = cell_entry[1];
        else
            top = cell_entry[0];
    end

    assign top_valid = (count_next != '0);

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (req_fire)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg.top_valid   <= top_valid;
            rsp_reg.top_key     <= top_valid ? top.key : '0;
            rsp_reg.top_value   <= top_valid ? top.value : '0;
            rsp_reg.entry_count <= count_next;
            rsp_reg.status      <= status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(CAPACITY))
        else $error("count above capacity");

    // occupied cells match the count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell occupancy disagrees with count");

    // accepted push grows the queue by one
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> count_reg == $past(count_reg) + COUNT_BITS'(1))
        else $error("push did not grow count");

    // response top flag follows its count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.top_valid == (rsp_reg.entry_count != '0)))
        else $error("top flag disagrees with count");
`endif

endmodule
